// ===== src/fp_dual_path_adder_core_defines.svh =====
// Assertion macros shared by the adder RTL.
// Depends on nothing; included by the top level.
`ifndef FP_DUAL_PATH_ADDER_CORE_DEFINES_SVH
`define FP_DUAL_PATH_ADDER_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define FPA_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FPA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

// ===== src/fpa_pkg.sv =====
// Shared constants and types of the dual-path adder.
// Depends on nothing.
package fpa_pkg;
    localparam int WordW = 25;
    localparam int FracW = 14;
    localparam int ExpW  = 8;
    localparam logic [1:0] ExnZero = 2'd0;
    localparam logic [1:0] ExnNorm = 2'd1;
    localparam logic [1:0] ExnInf  = 2'd2;
    localparam logic [1:0] ExnNan  = 2'd3;
    localparam logic [3:0] PairNormNorm = 4'h5;
    localparam logic [3:0] PairInfInf   = 4'hA;
    localparam logic [3:0] PairNanInf   = 4'hE;
    localparam logic [3:0] PairZeroZero = 4'h0;

    // Stage 1 to stage 2 record.
    typedef struct packed {
        logic [24:0] a;
        logic [1:0]  exn_b;
        logic        sb;
        logic        eff_sub;
        logic        close;
        logic [16:0] amb;
        logic [16:0] bma;
        logic [17:0] yop;
        logic        cin;
        logic        sticky;
    } t_s1;

    // Stage 2 to stage 3 record.
    typedef struct packed {
        logic [24:0] a;
        logic [1:0]  exn_b;
        logic        sb;
        logic        eff_sub;
        logic        close;
        logic        close_zero;
        logic        res_sign;
        logic [23:0] pre;
        logic        rnd;
    } t_s2;
endpackage

// ===== src/fpa_pipe_reg.sv =====
// One stallable pipeline stage: a valid bit and its payload.
// Depends on nothing.
module fpa_pipe_reg #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    logic         r_valid;
    logic [W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ===== src/fp_dual_path_adder_core.sv =====
// Top level of the dual-path floating-point adder, three register stages.
// Depends on fpa_pkg, fpa_pipe_reg and the defines header.
//
// channel | valid      | stall      | payload
// input   | i_valid    | o_stall    | i_operand_x, i_operand_y
// output  | o_valid    | i_stall    | o_sum
//
// One request enters per cycle while the output is not stalled; the sum is registered through stages 1, 2 and 3.
// The stages are order/align/subtract, normalize, round.
// Reset clears the stage valid bits only.
// A stall on the output freezes the whole pipeline; nothing is lost.
`include "fp_dual_path_adder_core_defines.svh"
module fp_dual_path_adder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [24:0] i_operand_x,
    input  logic [24:0] i_operand_y,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [24:0] o_sum
);
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Stage 1: order operands, close dual subtract, far alignment.
    fpa_pkg::t_s1 n_s1, s1;
    logic         v1;
    always_comb begin
        logic [1:0]  ex, ey;
        logic [7:0]  xx, xy, ea, eb, diff;
        logic [4:0]  sh;
        logic        full, swp, sa;
        logic [24:0] a, b;
        logic [16:0] ca, cb;
        logic [17:0] yv, shf;
        logic [13:0] fa, fb;
        ex = i_operand_x[24:23];
        ey = i_operand_y[24:23];
        xx = i_operand_x[21:14];
        xy = i_operand_y[21:14];
        swp = ((ex == ey) && (xx < xy)) || (ex < ey);
        a = swp ? i_operand_y : i_operand_x;
        b = swp ? i_operand_x : i_operand_y;
        ea = a[21:14];
        eb = b[21:14];
        diff = ea - eb;
        full = diff[7:5] != 3'd0;
        sh = diff[4:0];
        sa = a[22];
        fa = a[13:0];
        fb = b[13:0];
        ca = {2'b01, fa, 1'b0};
        cb = diff[0] ? {3'b001, fb} : {2'b01, fb, 1'b0};
        yv = {2'b01, fb, 2'b00};
        shf = full ? 18'd0 : (yv >> sh);
        n_s1.a = a;
        n_s1.exn_b = b[24:23];
        n_s1.sb = b[22];
        n_s1.eff_sub = sa ^ b[22];
        n_s1.close = (sa ^ b[22]) && (diff[7:1] == 7'd0);
        n_s1.amb = ca - cb;
        n_s1.bma = cb - ca;
        n_s1.sticky = full ? 1'b1 : ((yv & ((18'd1 << sh) - 18'd1)) != 18'd0);
        n_s1.yop = (sa ^ b[22]) ? ~shf : shf;
        n_s1.cin = (sa ^ b[22]) && !n_s1.sticky;
    end
    fpa_pipe_reg #(.W($bits(fpa_pkg::t_s1))) u_s1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(i_valid),
        .i_data(n_s1), .o_valid(v1), .o_data(s1));

    // Stage 2: leading-zero normalize and far add, pre-round word.
    fpa_pkg::t_s2 n_s2, s2;
    logic         v2;
    always_comb begin
        logic        neg;
        logic [15:0] d, nrm;
        logic [4:0]  nz;
        logic [9:0]  ea10, expc, expf;
        logic [17:0] sf;
        logic [13:0] fracf;
        logic        rb, sbt, rndf;
        neg = s1.amb[16];
        d = neg ? s1.bma[15:0] : s1.amb[15:0];
        nz = 5'd16;
        for (int k = 0; k < 16; k++) begin
            if (d[k]) nz = 5'(15 - k);
        end
        nrm = d << nz[3:0];
        if (d == 16'd0) nrm = 16'd0;
        ea10 = {2'b00, s1.a[21:14]};
        expc = ea10 - {5'd0, nz};
        sf = {2'b01, s1.a[13:0], 2'b00} + s1.yop + {17'd0, s1.cin};
        case (sf[17:16])
            2'd0: begin
                fracf = sf[14:1]; rb = sf[0]; sbt = s1.sticky; expf = ea10 - 10'd1;
            end
            2'd1: begin
                fracf = sf[15:2]; rb = sf[1]; sbt = sf[0] | s1.sticky; expf = ea10;
            end
            default: begin
                fracf = sf[16:3]; rb = sf[2]; sbt = (sf[1:0] != 2'd0) | s1.sticky;
                expf = ea10 + 10'd1;
            end
        endcase
        rndf = rb && (sbt || fracf[0]);
        n_s2.a = s1.a;
        n_s2.exn_b = s1.exn_b;
        n_s2.sb = s1.sb;
        n_s2.eff_sub = s1.eff_sub;
        n_s2.close = s1.close;
        n_s2.close_zero = d == 16'd0;
        n_s2.res_sign = (s1.close && d == 16'd0) ? 1'b0 : (s1.a[22] ^ (s1.close && neg));
        n_s2.pre = s1.close ? {expc, nrm[14:1]} : {expf, fracf};
        n_s2.rnd = s1.close ? (nrm[0] && nrm[1]) : rndf;
    end
    fpa_pipe_reg #(.W($bits(fpa_pkg::t_s2))) u_s2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v1),
        .i_data(n_s2), .o_valid(v2), .o_data(s2));

    // Stage 3: round and apply the exception rules.
    logic [24:0] n_sum;
    always_comb begin
        logic [23:0] rd;
        logic [3:0]  pair;
        logic [1:0]  exn;
        logic        sg;
        logic [21:0] es;
        rd = s2.pre + {23'd0, s2.rnd};
        pair = {s2.a[24:23], s2.exn_b};
        if (pair == fpa_pkg::PairNormNorm) begin
            if (s2.close && s2.close_zero) exn = fpa_pkg::ExnZero;
            else if (rd[23:22] == 2'd1) exn = fpa_pkg::ExnInf;
            else if (rd[23]) exn = fpa_pkg::ExnZero;
            else exn = fpa_pkg::ExnNorm;
            sg = s2.res_sign;
            es = rd[21:0];
        end else begin
            if (pair == fpa_pkg::PairInfInf)
                exn = s2.eff_sub ? fpa_pkg::ExnNan : fpa_pkg::ExnInf;
            else if (pair == fpa_pkg::PairNanInf) exn = fpa_pkg::ExnNan;
            else exn = s2.a[24:23];
            sg = (pair == fpa_pkg::PairZeroZero) ? (s2.a[22] & s2.sb) : s2.a[22];
            es = s2.a[21:0];
        end
        n_sum = {exn, sg, es};
    end
    fpa_pipe_reg #(.W(fpa_pkg::WordW)) u_s3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v2),
        .i_data(n_sum), .o_valid(o_valid), .o_data(o_sum));

    `FPA_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_sum))
    `FPA_ASSERT_IMP(a_stall_is_full, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `FPA_ASSERT_NEXT(a_flow, i_clk, i_rst_n, v2 && en, o_valid)
endmodule
